### hw/rtl/bpi_pkg.sv
// bpi_pkg: shared widths, constants and controller/datapath types of the break-point interpolator
package bpi_pkg;

   localparam int TIME_W    = 32;
   localparam int VALUE_W   = 32;
   localparam int SEG_W     = 6;
   localparam int PIU_W     = 7;
   localparam int FRAC_BITS = 16;

   localparam logic [PIU_W-1:0] PIU_RESET = 7'd2;

   // multiply split: low sixteen bits of the time difference, unsigned
   localparam int SPLIT_W = 16;
   localparam int DIFF_W  = TIME_W + 1;
   localparam int MOP_W   = DIFF_W - SPLIT_W;
   localparam int PROD_W  = MOP_W + VALUE_W;
   localparam int Q_W     = PROD_W + SPLIT_W + 1;
   localparam int SUM_W   = Q_W + 1;

   localparam logic signed [Q_W-1:0] ROUND_HALF = (Q_W'(1) << FRAC_BITS) >> 1;

   typedef struct packed {
      logic [TIME_W-1:0]         pt_time;
      logic signed [VALUE_W-1:0] pt_value;
      logic signed [VALUE_W-1:0] pt_slope;
      logic                      pt_jump;
   } bpi_entry_type;

   typedef struct packed {
      logic load_write;
      logic query_start;
      logic out_clamp;
      logic search_start;
      logic search_step;
      logic search_done;
      logic mul_lo;
      logic mul_hi;
      logic acc;
      logic out_interp;
   } bpi_cmd_type;

   typedef struct packed {
      logic is_query;
      logic clamp;
      logic search_more;
      logic out_free;
   } bpi_status_type;

endpackage

### hw/rtl/bpi_if.sv
// bpi_if: request and response channel interfaces
interface bpi_req_if;
   import bpi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [SEG_W-1:0]          point_index;
   logic [TIME_W-1:0]         point_time;
   logic signed [VALUE_W-1:0] point_value;
   logic signed [VALUE_W-1:0] point_slope;
   logic                      point_is_jump;
   logic [TIME_W-1:0]         query_time;

   modport source (output valid, kind, point_index, point_time, point_value, point_slope,
                   point_is_jump, query_time, input ready);
   modport sink (input valid, kind, point_index, point_time, point_value, point_slope,
                 point_is_jump, query_time, output ready);
endinterface

interface bpi_rsp_if;
   import bpi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] result_value;
   logic [SEG_W-1:0]          segment_index;
   logic                      saturated;

   modport source (output valid, result_value, segment_index, saturated, input ready);
   modport sink (input valid, result_value, segment_index, saturated, output ready);
endinterface

### hw/rtl/bpi_ctrl.sv
// bpi_ctrl: state machine sequencing loads, clamps, segment search, multiply and output
module bpi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bpi_pkg::bpi_status_type status,
   output bpi_pkg::bpi_cmd_type    cmd
);
   import bpi_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLAMP  = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_MUL_LO = 3'd3;
   localparam logic [2:0] ST_MUL_HI = 3'd4;
   localparam logic [2:0] ST_ACC    = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.is_query) begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_CLAMP;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         ST_CLAMP: begin
            if (status.clamp) begin
               // end points answer at once, once the output register is free
               if (status.out_free) begin
                  cmd.out_clamp = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.search_start = 1'b1;
               state_in         = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.search_more) begin
               cmd.search_step = 1'b1;
            end else begin
               cmd.search_done = 1'b1;
               state_in        = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.out_interp = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/bpi_datapath.sv
// bpi_datapath: point table, segment cache, multiply-add with rounding and saturation, output register
module bpi_datapath #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpi_pkg::bpi_cmd_type              cmd,
   output bpi_pkg::bpi_status_type           status,
   input  logic                              req_kind,
   input  logic [bpi_pkg::SEG_W-1:0]         req_point_index,
   input  logic [bpi_pkg::TIME_W-1:0]        req_point_time,
   input  logic signed [bpi_pkg::VALUE_W-1:0] req_point_value,
   input  logic signed [bpi_pkg::VALUE_W-1:0] req_point_slope,
   input  logic                              req_point_is_jump,
   input  logic [bpi_pkg::TIME_W-1:0]        req_query_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bpi_pkg::VALUE_W-1:0] rsp_result_value,
   output logic [bpi_pkg::SEG_W-1:0]         rsp_segment_index,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  logic [bpi_pkg::PIU_W-1:0]         csr_wr_data
);
   import bpi_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_FWD  = 2'd1;
   localparam logic [1:0] MODE_BWD  = 2'd2;
   localparam logic [1:0] MODE_JMP  = 2'd3;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(2147483647) - SUM_W'(1);

   bpi_entry_type tbl_mem [MAX_POINTS];

   logic [PIU_W-1:0]          points_ff;
   logic [IDX_W-1:0]          cached_ff, idx_ff, last_ff;
   logic                      first_ff;
   logic [1:0]                mode_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]         t_ff;
   bpi_entry_type             rd_a_ff, rd_b_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [PROD_W-1:0]  p_lo_ff, p_hi_ff;
   logic signed [Q_W-1:0]     q_ff;
   logic signed [VALUE_W-1:0] res_value_ff;
   logic [SEG_W-1:0]          res_seg_ff;
   logic                      res_sat_ff;

   logic [CNT_W-1:0]          n_cnt;
   logic [IDX_W-1:0]          n_last, top_idx, idx0, idx_next, addr_a, addr_b;
   logic                      rd_en, ld_ok;
   logic [IDX_W+SEG_W-1:0]    ld_wide, seg_wide, clamp_wide;
   logic [IDX_W-1:0]          ld_addr;
   logic                      clamp_lo, clamp_hi, fwd_c, bwd_c, jmp_c, more;
   logic [1:0]                mode_eff;
   logic signed [MOP_W-1:0]   mop;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]   sum;
   logic signed [VALUE_W-1:0] sum_sat;
   logic                      sum_clip;

   // effective point count, clamped to one..table depth
   always_comb begin
      if (points_ff == '0) begin
         n_cnt = CNT_W'(1);
      end else if (int'(points_ff) > MAX_POINTS) begin
         n_cnt = CNT_W'(MAX_POINTS);
      end else begin
         n_cnt = CNT_W'(points_ff);
      end
   end

   assign n_last  = IDX_W'(n_cnt - CNT_W'(1));
   assign top_idx = last_ff - IDX_W'(1);
   assign idx0    = (cached_ff > top_idx) ? top_idx : cached_ff;

   assign ld_ok   = int'(req_point_index) < MAX_POINTS;
   assign ld_wide = {{IDX_W{1'b0}}, req_point_index};
   assign ld_addr = ld_wide[IDX_W-1:0];

   // search direction is fixed by the first look and then kept
   assign fwd_c = t_ff >= rd_b_ff.pt_time;
   assign bwd_c = t_ff < rd_a_ff.pt_time;
   assign jmp_c = rd_a_ff.pt_jump;

   always_comb begin
      if (!first_ff) begin
         mode_eff = mode_ff;
      end else if (fwd_c) begin
         mode_eff = MODE_FWD;
      end else if (bwd_c) begin
         mode_eff = MODE_BWD;
      end else if (jmp_c) begin
         mode_eff = MODE_JMP;
      end else begin
         mode_eff = MODE_NONE;
      end
   end

   always_comb begin
      case (mode_eff)
         MODE_FWD: more = fwd_c && (idx_ff < top_idx);
         MODE_BWD: more = bwd_c && (idx_ff != '0);
         MODE_JMP: more = jmp_c && (idx_ff < top_idx);
         default:  more = 1'b0;
      endcase
   end

   assign idx_next = (mode_eff == MODE_BWD) ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);

   always_comb begin
      addr_a = idx_ff;
      addr_b = idx_ff + IDX_W'(1);
      if (cmd.query_start) begin
         addr_a = '0;
         addr_b = n_last;
      end else if (cmd.search_start) begin
         addr_a = idx0;
         addr_b = idx0 + IDX_W'(1);
      end else if (cmd.search_step) begin
         addr_a = idx_next;
         addr_b = idx_next + IDX_W'(1);
      end
   end

   assign rd_en = cmd.query_start || cmd.search_start || cmd.search_step;

   assign clamp_lo = t_ff <= rd_a_ff.pt_time;
   assign clamp_hi = t_ff >= rd_b_ff.pt_time;

   assign status.is_query    = req_kind;
   assign status.clamp       = clamp_lo || clamp_hi;
   assign status.search_more = more;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_write && ld_ok) begin
         tbl_mem[ld_addr] <= '{pt_time: req_point_time, pt_value: req_point_value,
                               pt_slope: req_point_slope, pt_jump: req_point_is_jump};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= tbl_mem[addr_a];
         rd_b_ff <= tbl_mem[addr_b];
      end
   end

   // shared multiplier: low sixteen bits unsigned, then the signed upper part
   assign mop  = cmd.mul_lo ? $signed({1'b0, diff_ff[SPLIT_W-1:0]}) : diff_ff[DIFF_W-1:SPLIT_W];
   assign prod = mop * rd_a_ff.pt_slope;

   // half-up rounding is a floor shift after adding one half
   assign sum = SUM_W'(rd_a_ff.pt_value) + SUM_W'(q_ff >>> FRAC_BITS);

   always_comb begin
      if (sum > SAT_MAX) begin
         sum_sat  = VALUE_W'(SAT_MAX);
         sum_clip = 1'b1;
      end else if (sum < SAT_MIN) begin
         sum_sat  = VALUE_W'(SAT_MIN);
         sum_clip = 1'b1;
      end else begin
         sum_sat  = VALUE_W'(sum);
         sum_clip = 1'b0;
      end
   end

   assign seg_wide   = {{SEG_W{1'b0}}, idx_ff};
   assign clamp_wide = {{SEG_W{1'b0}}, last_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_clamp || cmd.out_interp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff    <= PIU_RESET;
         cached_ff    <= '0;
         idx_ff       <= '0;
         last_ff      <= '0;
         first_ff     <= 1'b0;
         mode_ff      <= MODE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            points_ff <= csr_wr_data;
         end
         if (cmd.query_start) begin
            last_ff <= n_last;
         end
         if (cmd.search_start) begin
            idx_ff   <= idx0;
            first_ff <= 1'b1;
         end else if (cmd.search_step) begin
            idx_ff   <= idx_next;
            first_ff <= 1'b0;
            mode_ff  <= mode_eff;
         end
         if (cmd.search_done) begin
            cached_ff <= idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         t_ff <= req_query_time;
      end
      if (cmd.search_done) begin
         diff_ff <= $signed({1'b0, t_ff}) - $signed({1'b0, rd_a_ff.pt_time});
      end
      if (cmd.mul_lo) begin
         p_lo_ff <= prod;
      end
      if (cmd.mul_hi) begin
         p_hi_ff <= prod;
      end
      if (cmd.acc) begin
         q_ff <= (Q_W'(p_hi_ff) <<< SPLIT_W) + Q_W'(p_lo_ff) + ROUND_HALF;
      end
      if (cmd.out_clamp) begin
         res_sat_ff <= 1'b0;
         if (clamp_lo) begin
            res_value_ff <= rd_a_ff.pt_value;
            res_seg_ff   <= '0;
         end else begin
            res_value_ff <= rd_b_ff.pt_value;
            res_seg_ff   <= clamp_wide[SEG_W-1:0];
         end
      end else if (cmd.out_interp) begin
         res_value_ff <= sum_sat;
         res_seg_ff   <= seg_wide[SEG_W-1:0];
         res_sat_ff   <= sum_clip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = res_value_ff;
   assign rsp_segment_index = res_seg_ff;
   assign rsp_saturated     = res_sat_ff;

endmodule

### hw/rtl/breakpoint_interpolator.sv
// breakpoint_interpolator: top level joining the controller and the datapath
// Piecewise linear function of time over a table of up to MAX_POINTS break points.
// req_bus carries one word per item: kind 0 loads a table entry at point_index,
// kind 1 asks for the value at query_time. rsp_bus returns one word per query,
// none per load. csr_wr_en/csr_wr_data set the number of points in use (reset 2).
// A load is written to the table on acceptance and the block stays ready. A query
// clamped to the first or last point reads both end entries, then registers that
// end point's value once the output register is free and returns to idle. An
// interpolated query walks the cached segment index one entry per cycle through
// the two-read-port table, then runs a two-step split multiply, a rounding add
// and the saturating sum, whose result is registered once the output register
// is free. No new item is accepted while a query is in progress.
// Results sit in an output register; while the receiver stalls the block still
// accepts the next item and holds its own result until that register frees.
// Reset clears the handshake, the state machine and the cached segment; the
// table contents are not cleared and must be loaded before they are queried.
module breakpoint_interpolator #(
   parameter int MAX_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   bpi_req_if.sink                   req_bus,
   bpi_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [bpi_pkg::PIU_W-1:0] csr_wr_data
);
   import bpi_pkg::*;

   bpi_cmd_type    cmd;
   bpi_status_type status;

   bpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpi_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_bus.kind),
      .req_point_index   (req_bus.point_index),
      .req_point_time    (req_bus.point_time),
      .req_point_value   (req_bus.point_value),
      .req_point_slope   (req_bus.point_slope),
      .req_point_is_jump (req_bus.point_is_jump),
      .req_query_time    (req_bus.query_time),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_result_value  (rsp_bus.result_value),
      .rsp_segment_index (rsp_bus.segment_index),
      .rsp_saturated     (rsp_bus.saturated),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

endmodule

### hw/rtl/bpi_checker.sv
// bpi_checker: port-level assertions on the interpolator, bound to the top level
module bpi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_kind,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a query keeps the block busy in the following cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> !req_ready)
      else $error("ready after query acceptance");

   // a load leaves the block ready in the following cycle
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind |=> req_ready)
      else $error("not ready after load");

   // a new result only appears out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word without a query in progress");

endmodule

bind breakpoint_interpolator bpi_checker u_bpi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_kind  (req_bus.kind),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
